>>> hdl/csvt_pkg.sv
package csvt_pkg;

	// Queue between the byte parser and the result serializer
	localparam int unsigned QueueDepth = 4;

	// Results one input byte can cause: held CR, the byte itself, end-of-input flush
	localparam int unsigned MaxResults = 3;

	localparam logic [7:0] ByteLf      = 8'h0A;
	localparam logic [7:0] ByteCr      = 8'h0D;
	localparam logic [7:0] DelimReset  = 8'h2C;
	localparam logic [7:0] QuoteReset  = 8'h22;
	localparam logic [7:0] EscapeReset = 8'h5C;

	typedef enum logic [1:0] {
		REG_DELIM  = 2'd0,
		REG_QUOTE  = 2'd1,
		REG_ESCAPE = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		FM_START = 3'd0,
		FM_PLAIN = 3'd1,
		FM_INQ   = 3'd2,
		FM_ESC   = 3'd3,
		FM_QSEEN = 3'd4,
		FM_SKIP  = 3'd5
	} field_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       field_end;
		logic       row_end;
	} result_t;

	typedef struct packed {
		logic [1:0]                   num;
		result_t [MaxResults-1:0]     res;
	} bundle_t;

	typedef struct packed {
		logic [7:0] delim;
		logic [7:0] quote;
		logic [7:0] escape;
	} char_regs_t;

	typedef struct packed {
		field_mode_t mode;
		logic        nonempty;
		logic        emit;
		result_t     res;
	} parse_t;

	// Advance the field state machine by one byte
	function automatic parse_t parse_byte(field_mode_t mode, logic nonempty, logic [7:0] b,
			char_regs_t c);
		parse_t p;
		result_t byte_res;
		result_t close_res;
		byte_res  = '{data: b, has_byte: 1'b1, field_end: 1'b0, row_end: 1'b0};
		close_res = '{data: 8'h00, has_byte: 1'b0, field_end: 1'b1, row_end: 1'b0};
		p.mode     = mode;
		p.nonempty = nonempty;
		p.emit     = 1'b0;
		p.res      = byte_res;
		case (mode)
			FM_START: begin
				p.nonempty = 1'b1;
				if (b == c.quote) begin
					p.mode = FM_INQ;
				end else if (b == c.delim) begin
					p.emit     = 1'b1;
					p.res      = close_res;
					p.mode     = FM_START;
					p.nonempty = 1'b0;
				end else begin
					p.emit = 1'b1;
					p.mode = FM_PLAIN;
				end
			end
			FM_PLAIN: begin
				p.emit = 1'b1;
				if (b == c.delim) begin
					p.res      = close_res;
					p.mode     = FM_START;
					p.nonempty = 1'b0;
				end
			end
			FM_INQ: begin
				if (b == c.escape) begin
					p.mode = FM_ESC;
				end else if (b == c.quote) begin
					p.mode = FM_QSEEN;
				end else begin
					p.emit = 1'b1;
				end
			end
			FM_ESC: begin
				p.emit = 1'b1;
				p.mode = FM_INQ;
			end
			FM_QSEEN: begin
				if (b == c.quote) begin
					p.emit = 1'b1;
					p.mode = FM_INQ;
				end else if (b == c.delim) begin
					p.emit     = 1'b1;
					p.res      = close_res;
					p.mode     = FM_START;
					p.nonempty = 1'b0;
				end else begin
					p.mode = FM_SKIP;
				end
			end
			default: begin
				if (b == c.delim) begin
					p.emit     = 1'b1;
					p.res      = close_res;
					p.mode     = FM_START;
					p.nonempty = 1'b0;
				end
			end
		endcase
		return p;
	endfunction

	// Result that closes a row, given the field state at that point
	function automatic result_t finish_result(field_mode_t mode, logic nonempty, char_regs_t c);
		result_t r;
		r = '{data: 8'h00, has_byte: 1'b0, field_end: 1'b0, row_end: 1'b1};
		if (nonempty) begin
			r.field_end = 1'b1;
			if (mode == FM_ESC && c.escape != c.quote) begin
				r.data     = c.escape;
				r.has_byte = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

>>> hdl/csvt_front.sv
module csvt_front
	import csvt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       push,
	output bundle_t    push_data
);

	char_regs_t  chars_q;
	field_mode_t mode_q;
	logic        parity_q;
	logic        held_q;
	logic        fne_q;
	logic        rne_q;

	field_mode_t mode_d;
	logic        parity_d;
	logic        held_d;
	logic        fne_d;
	logic        rne_d;

	logic        accept;
	logic        is_quote;
	logic        ends;
	logic        va;
	logic        vb;
	logic        vc;
	result_t     ra;
	result_t     rb;
	result_t     rc;
	parse_t      pa;
	parse_t      pb;

	assign accept   = in_valid & in_ready;
	assign is_quote = (in_byte == chars_q.quote);
	assign ends     = !is_quote && (in_byte == ByteLf) && !parity_q;

	// Classify the byte and work out every result it causes
	always_comb begin
		mode_d   = mode_q;
		fne_d    = fne_q;
		rne_d    = rne_q;
		held_d   = held_q;
		parity_d = parity_q ^ is_quote;
		va = 1'b0;
		vb = 1'b0;
		vc = 1'b0;
		ra = '0;
		rb = '0;
		rc = '0;

		// release a held CR as an ordinary byte unless the row ends here
		pa = parse_byte(mode_d, fne_d, ByteCr, chars_q);
		if (held_q) begin
			held_d = 1'b0;
			if (!ends) begin
				mode_d = pa.mode;
				fne_d  = pa.nonempty;
				va     = pa.emit;
				ra     = pa.res;
			end
		end

		pb = parse_byte(mode_d, fne_d, in_byte, chars_q);
		if (ends) begin
			vb       = 1'b1;
			rb       = finish_result(mode_d, fne_d, chars_q);
			mode_d   = FM_START;
			fne_d    = 1'b0;
			parity_d = 1'b0;
			rne_d    = 1'b0;
			held_d   = 1'b0;
		end else if (in_byte == ByteCr && !end_of_input) begin
			held_d = 1'b1;
			rne_d  = 1'b1;
		end else begin
			rne_d  = 1'b1;
			mode_d = pb.mode;
			fne_d  = pb.nonempty;
			vb     = pb.emit;
			rb     = pb.res;
		end

		// flush the last row at end of input
		if (end_of_input && rne_d) begin
			vc       = 1'b1;
			rc       = finish_result(mode_d, fne_d, chars_q);
			mode_d   = FM_START;
			fne_d    = 1'b0;
			parity_d = 1'b0;
			rne_d    = 1'b0;
			held_d   = 1'b0;
		end
	end

	// Pack the results into the lowest slots
	always_comb begin
		push_data.num    = {1'b0, va} + {1'b0, vb} + {1'b0, vc};
		push_data.res[0] = va ? ra : (vb ? rb : rc);
		push_data.res[1] = (va && vb) ? rb : rc;
		push_data.res[2] = rc;
	end

	assign push = accept && (push_data.num != 2'd0);

	// Hold parser state and character registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q.delim  <= DelimReset;
			chars_q.quote  <= QuoteReset;
			chars_q.escape <= EscapeReset;
			mode_q   <= FM_START;
			parity_q <= 1'b0;
			held_q   <= 1'b0;
			fne_q    <= 1'b0;
			rne_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_DELIM:  chars_q.delim  <= cfg_data;
					REG_QUOTE:  chars_q.quote  <= cfg_data;
					REG_ESCAPE: chars_q.escape <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				mode_q   <= mode_d;
				parity_q <= parity_d;
				held_q   <= held_d;
				fne_q    <= fne_d;
				rne_q    <= rne_d;
			end
		end
	end

endmodule

>>> hdl/csvt_queue.sv
module csvt_queue
	import csvt_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output logic    full,
	output logic    empty,
	output bundle_t head
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	bundle_t         mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == FullCnt);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store incoming requests
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/csvt_back.sv
module csvt_back
	import csvt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  bundle_t    head,
	input  logic       out_ready,
	output logic       pop,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       field_end,
	output logic       row_end,
	output logic       last_of_run
);

	logic [1:0] idx_q;
	result_t    cur;
	logic       take;

	// Select the current result of the head request
	always_comb begin
		case (idx_q)
			2'd0:    cur = head.res[0];
			2'd1:    cur = head.res[1];
			default: cur = head.res[2];
		endcase
	end

	assign out_valid   = !empty;
	assign out_byte    = cur.data;
	assign has_byte    = cur.has_byte;
	assign field_end   = cur.field_end;
	assign row_end     = cur.row_end;
	assign last_of_run = (idx_q == head.num - 2'd1);
	assign take        = out_valid && out_ready;
	assign pop         = take && last_of_run;

	// Step through the results, drop the request after its last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= last_of_run ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

>>> hdl/csv_row_field_tokenizer.sv
// CSV tokenizer: splits a byte stream into unescaped field bytes with
// field-end and row-end marks.
// Input channel (in_valid/in_ready): one file byte per request, with
// end_of_input set on the last byte of the file to flush the final row.
// Output channel (out_valid/out_ready): one result per request; last_of_run
// marks the final result caused by an input byte. Bytes that cause no
// result (opening quote, held CR, skipped bytes) produce nothing.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 delimiter, 1 quote, 2 escape); write only while the block is idle.
// Each byte's results are registered in the queue when the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result
// and out_ready stays high; a byte that gives two or three results takes
// one output request per result, limited by the single-result output port.
// A queue of QUEUE_DEPTH byte results sits between the parser and the
// output; in_ready drops only when it is full, so a stalled receiver
// backs up into the input after that many requests.
// Reset clears the parser state and queue and loads comma, double quote
// and backslash as delimiter, quote and escape characters.
module csv_row_field_tokenizer
	import csvt_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       field_end,
	output logic       row_end,
	output logic       last_of_run
);

	logic    push;
	logic    pop;
	logic    full;
	logic    empty;
	bundle_t push_data;
	bundle_t head;

	assign in_ready = !full;

	csvt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.push         (push),
		.push_data    (push_data)
	);

	csvt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	csvt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.out_ready   (out_ready),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.has_byte    (has_byte),
		.field_end   (field_end),
		.row_end     (row_end),
		.last_of_run (last_of_run)
	);

endmodule
